// File: hw/rtl/vsf_pkg.sv
// Shared types and constants of the voxel shape fill engine.
// Grid geometry, field widths, opcodes, register indexes and pipeline structs.
// No dependencies.
`default_nettype none

package vsf_pkg;

    localparam int GRID_X   = 32;
    localparam int GRID_Y   = 32;
    localparam int GRID_Z   = 32;
    localparam int GRID_MAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                                : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
    localparam int CELLS    = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COORD_W  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;

    localparam int OP_W       = 4;
    localparam int POS_W      = 8;
    localparam int RAD_W      = 7;
    localparam int COLOR_W    = 8;
    localparam int SIZE_W     = 6;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CELL_W     = 1 + 4 * COLOR_W;

    localparam int EXT_W  = 7;           // active extent, 0..32
    localparam int BND_W  = 9;           // signed bound arithmetic
    localparam int DIFF_W = 9;           // signed voxel minus center
    localparam int SQ_W   = 16;          // squared offset
    localparam int RSQ_W  = 2 * RAD_W;   // squared radius
    localparam int COEF_W = 2 * RSQ_W;   // product of two squared radii
    localparam int LIM_W  = 3 * RSQ_W;   // product of three squared radii
    localparam int PROD_W = SQ_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET_VOX = 4'd0,
        OP_CLR_VOX = 4'd1,
        OP_SET_BOX = 4'd2,
        OP_CLR_BOX = 4'd3,
        OP_SET_SPH = 4'd4,
        OP_CLR_SPH = 4'd5,
        OP_SET_ELL = 4'd6,
        OP_CLR_ELL = 4'd7,
        OP_READ    = 4'd8
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP_SQ,
        S_PREP_PAIR,
        S_PREP_LIM,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic               shown;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } t_cell;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [COEF_W-1:0]       kx;
        logic [COEF_W-1:0]       ky;
        logic [COEF_W-1:0]       kz;
        logic [LIM_W-1:0]        lim;
        logic                    use_test;
    } t_geom;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic              busy;
    } t_hit_stat;

endpackage

`default_nettype wire

// File: hw/rtl/vsf_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
// Depends on vsf_pkg.
`default_nettype none

interface vsf_cmd_if import vsf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    logic signed [POS_W-1:0] end_z;
    logic [RAD_W-1:0]        radius_x;
    logic [RAD_W-1:0]        radius_y;
    logic [RAD_W-1:0]        radius_z;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, end_x, end_y, end_z,
                    radius_x, radius_y, radius_z, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, end_x, end_y, end_z,
                    radius_x, radius_y, radius_z, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/vsf_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on vsf_pkg.
`default_nettype none

interface vsf_res_if import vsf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               status;
    logic               read_shown;
    logic [COLOR_W-1:0] read_red;
    logic [COLOR_W-1:0] read_green;
    logic [COLOR_W-1:0] read_blue;
    logic [COLOR_W-1:0] read_alpha;
    logic [CNT_W-1:0]   shown_count;

    modport source (output valid, status, read_shown, read_red, read_green, read_blue,
                    read_alpha, shown_count, input ready);
    modport sink   (input valid, status, read_shown, read_red, read_green, read_blue,
                    read_alpha, shown_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/vsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module vsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// File: hw/rtl/vsf_hit.sv
// Three-stage voxel hit test: squared offsets, weighting, sum and compare.
// Depends on vsf_pkg.
`default_nettype none

module vsf_hit import vsf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic               i_coord_valid,
    input  logic [COORD_W-1:0] i_cx,
    input  logic [COORD_W-1:0] i_cy,
    input  logic [COORD_W-1:0] i_cz,
    output t_hit_stat          o_stat
);
    logic signed [DIFF_W-1:0]   w_dx, w_dy, w_dz;
    logic signed [2*DIFF_W-1:0] w_mx, w_my, w_mz;
    logic [ADDR_W-1:0]          w_addr;
    logic [SUM_W-1:0]           w_sum;

    logic                r_v1, r_v2, r_v3;
    logic [SQ_W-1:0]     r_sqx, r_sqy, r_sqz;
    logic [PROD_W-1:0]   r_prx, r_pry, r_prz;
    logic [ADDR_W-1:0]   r_addr1, r_addr2, r_addr3;
    logic                r_hit3;

    // stage 1: offsets from center, squared
    assign w_dx = $signed(DIFF_W'(i_cx)) - DIFF_W'(i_geom.px);
    assign w_dy = $signed(DIFF_W'(i_cy)) - DIFF_W'(i_geom.py);
    assign w_dz = $signed(DIFF_W'(i_cz)) - DIFF_W'(i_geom.pz);
    assign w_mx = w_dx * w_dx;
    assign w_my = w_dy * w_dy;
    assign w_mz = w_dz * w_dz;
    assign w_addr = ADDR_W'(i_cx) * ADDR_W'(GRID_Y * GRID_Z)
                  + ADDR_W'(i_cy) * ADDR_W'(GRID_Z) + ADDR_W'(i_cz);

    // stage 3: weighted sum against the limit
    assign w_sum = SUM_W'(r_prx) + SUM_W'(r_pry) + SUM_W'(r_prz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_coord_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx   <= w_mx[SQ_W-1:0];
        r_sqy   <= w_my[SQ_W-1:0];
        r_sqz   <= w_mz[SQ_W-1:0];
        r_addr1 <= w_addr;
        r_prx   <= PROD_W'(r_sqx) * PROD_W'(i_geom.kx);
        r_pry   <= PROD_W'(r_sqy) * PROD_W'(i_geom.ky);
        r_prz   <= PROD_W'(r_sqz) * PROD_W'(i_geom.kz);
        r_addr2 <= r_addr1;
        r_hit3  <= !i_geom.use_test || (w_sum <= SUM_W'(i_geom.lim));
        r_addr3 <= r_addr2;
    end

    assign o_stat.valid = r_v3;
    assign o_stat.hit   = r_hit3;
    assign o_stat.addr  = r_addr3;
    assign o_stat.busy  = r_v1 | r_v2 | r_v3;
endmodule

`default_nettype wire

// File: hw/rtl/voxel_shape_fill_engine_core.sv
// Voxel shape fill engine, top level: command decode, scan sequencer, voxel RAM
// read-modify-write and shown-voxel count. Depends on vsf_pkg, vsf_cmd_if,
// vsf_res_if, vsf_ram and vsf_hit.
`default_nettype none

// The engine keeps a GRID_X*GRID_Y*GRID_Z voxel store (shown flag plus RGBA) in
// one RAM and works on one command item at a time; i_cmd.ready is high only
// while the engine is idle. After reset the RAM is swept to zero, one voxel per
// cycle, over all CELLS (32768) voxels, before the first item is taken;
// configuration writes are taken at any time. Every voxel a command scans costs
// one RAM read and, for a hit of a write command, one write-back, one voxel per
// cycle. A single voxel or read scans one voxel, a box its clipped volume, a
// sphere or ellipsoid the active grid volume (sizes capped at 32); an empty or
// ignored item skips the scan. The result then waits on o_res.ready. Sphere and
// ellipsoid tests run exactly in integers through a three-stage multiply
// pipeline; the result carries the shown count after the command.
module voxel_shape_fill_engine_core import vsf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vsf_cmd_if.sink               i_cmd,
    vsf_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_state r_state, n_state;

    // configuration
    logic [COLOR_W-1:0] r_paint_red, r_paint_green, r_paint_blue, r_paint_alpha;
    logic [SIZE_W-1:0]  r_size_x, r_size_y, r_size_z;

    // latched command
    logic                    r_on, r_is_read, r_sphere, r_use_test, r_status;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [RAD_W-1:0]        r_rx, r_ry, r_rz;
    logic [RSQ_W-1:0]        r_a2, r_b2, r_c2;
    logic [COEF_W-1:0]       r_kx, r_ky, r_kz;
    logic [LIM_W-1:0]        r_lim;

    // scan counters, inclusive bounds
    logic [COORD_W-1:0] r_lo [3];
    logic [COORD_W-1:0] r_hi [3];
    logic [COORD_W-1:0] r_c  [3];
    logic               r_gen;
    logic               w_last;

    // write-back stage
    logic              r_wb_valid, r_wb_hit;
    logic [ADDR_W-1:0] r_wb_addr;
    t_cell             w_old, w_new, r_rd;
    logic [CNT_W-1:0]  r_total;
    logic [ADDR_W-1:0] r_clr_cnt;

    // RAM ports
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_cell             w_wdata;
    logic [CELL_W-1:0] w_rdata;

    t_geom     w_geom;
    t_hit_stat w_stat;

    // decode of the offered item
    logic                    w_accept, w_go_scan, w_go_prep, w_bad_coord;
    logic signed [BND_W-1:0] w_pos [3];
    logic signed [BND_W-1:0] w_end [3];
    logic signed [BND_W-1:0] w_ext [3];
    logic signed [BND_W-1:0] w_blo [3];
    logic signed [BND_W-1:0] w_bhi [3];
    logic [2:0]              w_in, w_box_ok, w_grid_ok;
    logic [COORD_W-1:0]      w_lo [3];
    logic [COORD_W-1:0]      w_hi [3];
    logic [SIZE_W-1:0]       w_size [3];
    logic [EXT_W-1:0]        w_grid [3];
    logic [BND_W-1:0]        w_bhi_m1 [3];
    logic [BND_W-1:0]        w_ext_m1 [3];

    assign w_accept = i_cmd.valid && i_cmd.ready;

    // per-axis clipping: active extent, voxel inside test, box clip
    always_comb begin
        w_pos[0]  = BND_W'(i_cmd.pos_x);
        w_pos[1]  = BND_W'(i_cmd.pos_y);
        w_pos[2]  = BND_W'(i_cmd.pos_z);
        w_end[0]  = BND_W'(i_cmd.end_x);
        w_end[1]  = BND_W'(i_cmd.end_y);
        w_end[2]  = BND_W'(i_cmd.end_z);
        w_size[0] = r_size_x;
        w_size[1] = r_size_y;
        w_size[2] = r_size_z;
        w_grid[0] = EXT_W'(GRID_X);
        w_grid[1] = EXT_W'(GRID_Y);
        w_grid[2] = EXT_W'(GRID_Z);
        for (int a = 0; a < 3; a++) begin
            w_ext[a] = (EXT_W'(w_size[a]) < w_grid[a]) ? $signed(BND_W'(w_size[a]))
                                                        : $signed(BND_W'(w_grid[a]));
            w_in[a]      = (w_pos[a] >= 0) && (w_pos[a] < w_ext[a]);
            w_blo[a]     = (w_pos[a] < 0) ? '0 : w_pos[a];
            w_bhi[a]     = (w_end[a] > w_ext[a]) ? w_ext[a] : w_end[a];
            w_box_ok[a]  = w_blo[a] < w_bhi[a];
            w_grid_ok[a] = w_ext[a] > 0;
            w_bhi_m1[a]  = w_bhi[a] - BND_W'(1);
            w_ext_m1[a]  = w_ext[a] - BND_W'(1);
            w_lo[a]      = '0;
            w_hi[a]      = '0;
        end
        w_go_scan   = 1'b0;
        w_go_prep   = 1'b0;
        w_bad_coord = 1'b0;
        unique case (i_cmd.opcode) inside
            OP_SET_VOX, OP_CLR_VOX, OP_READ: begin
                w_bad_coord = !(&w_in);
                w_go_scan   = &w_in;
                for (int a = 0; a < 3; a++) begin
                    w_lo[a] = w_pos[a][COORD_W-1:0];
                    w_hi[a] = w_pos[a][COORD_W-1:0];
                end
            end
            OP_SET_BOX, OP_CLR_BOX: begin
                w_go_scan = &w_box_ok;
                for (int a = 0; a < 3; a++) begin
                    w_lo[a] = w_blo[a][COORD_W-1:0];
                    w_hi[a] = w_bhi_m1[a][COORD_W-1:0];
                end
            end
            OP_SET_SPH, OP_CLR_SPH: begin
                w_go_prep = &w_grid_ok;
                for (int a = 0; a < 3; a++) begin
                    w_hi[a] = w_ext_m1[a][COORD_W-1:0];
                end
            end
            OP_SET_ELL, OP_CLR_ELL: begin
                w_go_prep = (&w_grid_ok) && (i_cmd.radius_x != '0)
                          && (i_cmd.radius_y != '0) && (i_cmd.radius_z != '0);
                for (int a = 0; a < 3; a++) begin
                    w_hi[a] = w_ext_m1[a][COORD_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_clr_cnt == ADDR_W'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    if (w_go_scan)      n_state = S_SCAN;
                    else if (w_go_prep) n_state = S_PREP_SQ;
                    else                n_state = S_RESP;
                end
            end
            S_PREP_SQ:   n_state = S_PREP_PAIR;
            S_PREP_PAIR: n_state = S_PREP_LIM;
            S_PREP_LIM:  n_state = S_SCAN;
            S_SCAN: begin
                if (!r_gen && !w_stat.busy && !r_wb_valid) n_state = S_RESP;
            end
            S_RESP:      if (o_res.ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_cmd.ready = 1'b0;
        o_res.valid = 1'b0;
        unique case (r_state)
            S_IDLE:  i_cmd.ready = 1'b1;
            S_RESP:  o_res.valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint_red   <= '0;
            r_paint_green <= '0;
            r_paint_blue  <= '0;
            r_paint_alpha <= '0;
            r_size_x      <= SIZE_W'(32);
            r_size_y      <= SIZE_W'(32);
            r_size_z      <= SIZE_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED:    r_paint_red   <= i_cfg_data;
                CFG_GREEN:  r_paint_green <= i_cfg_data;
                CFG_BLUE:   r_paint_blue  <= i_cfg_data;
                CFG_ALPHA:  r_paint_alpha <= i_cfg_data;
                CFG_SIZE_X: r_size_x      <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y: r_size_y      <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z: r_size_z      <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // latch the command; sphere and ellipsoid weights in S_PREP_SQ, S_PREP_PAIR and S_PREP_LIM
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_on       <= !i_cmd.opcode[0];
            r_is_read  <= i_cmd.opcode == OP_READ;
            r_sphere   <= (i_cmd.opcode == OP_SET_SPH) || (i_cmd.opcode == OP_CLR_SPH);
            r_use_test <= w_go_prep;
            r_status   <= w_bad_coord;
            r_px       <= i_cmd.pos_x;
            r_py       <= i_cmd.pos_y;
            r_pz       <= i_cmd.pos_z;
            r_rx       <= i_cmd.radius_x;
            r_ry       <= i_cmd.radius_y;
            r_rz       <= i_cmd.radius_z;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= w_lo[a];
                r_hi[a] <= w_hi[a];
            end
        end
        if (r_state == S_PREP_SQ) begin
            r_a2 <= RSQ_W'(r_rx) * RSQ_W'(r_rx);
            r_b2 <= RSQ_W'(r_ry) * RSQ_W'(r_ry);
            r_c2 <= RSQ_W'(r_rz) * RSQ_W'(r_rz);
        end
        if (r_state == S_PREP_PAIR) begin
            r_kx <= r_sphere ? COEF_W'(1) : COEF_W'(r_b2) * COEF_W'(r_c2);
            r_ky <= r_sphere ? COEF_W'(1) : COEF_W'(r_a2) * COEF_W'(r_c2);
            r_kz <= r_sphere ? COEF_W'(1) : COEF_W'(r_a2) * COEF_W'(r_b2);
        end
        if (r_state == S_PREP_LIM) begin
            r_lim <= r_sphere ? LIM_W'(r_a2) : LIM_W'(r_kz) * LIM_W'(r_c2);
        end
    end

    // coordinate generator, z fastest
    assign w_last = (r_c[0] == r_hi[0]) && (r_c[1] == r_hi[1]) && (r_c[2] == r_hi[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 1'b0;
        end else if ((r_state == S_IDLE && w_accept && w_go_scan) || r_state == S_PREP_LIM) begin
            r_gen <= 1'b1;
        end else if (r_gen && w_last) begin
            r_gen <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= w_lo[a];
            end
        end else if (r_gen) begin
            if (r_c[2] != r_hi[2]) begin
                r_c[2] <= r_c[2] + COORD_W'(1);
            end else begin
                r_c[2] <= r_lo[2];
                if (r_c[1] != r_hi[1]) begin
                    r_c[1] <= r_c[1] + COORD_W'(1);
                end else begin
                    r_c[1] <= r_lo[1];
                    r_c[0] <= r_c[0] + COORD_W'(1);
                end
            end
        end
    end

    assign w_geom.px       = r_px;
    assign w_geom.py       = r_py;
    assign w_geom.pz       = r_pz;
    assign w_geom.kx       = r_kx;
    assign w_geom.ky       = r_ky;
    assign w_geom.kz       = r_kz;
    assign w_geom.lim      = r_lim;
    assign w_geom.use_test = r_use_test;

    vsf_hit u_hit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (w_geom),
        .i_coord_valid (r_gen),
        .i_cx          (r_c[0]),
        .i_cy          (r_c[1]),
        .i_cz          (r_c[2]),
        .o_stat        (w_stat)
    );

    // voxel store: read at hit-test output, write back in the next cycle.
    // Addresses within one command never repeat, so no forwarding is needed.
    assign w_old = t_cell'(w_rdata);

    always_comb begin
        w_new = w_old;
        if (r_on) begin
            w_new.shown = 1'b1;
            w_new.red   = r_paint_red;
            w_new.green = r_paint_green;
            w_new.blue  = r_paint_blue;
            w_new.alpha = r_paint_alpha;
        end else begin
            w_new.shown = 1'b0;
        end
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_cnt;
            w_wdata = '0;
        end else begin
            w_we    = r_wb_valid && r_wb_hit && !r_is_read;
            w_waddr = r_wb_addr;
            w_wdata = w_new;
        end
    end

    vsf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_stat.valid),
        .i_raddr (w_stat.addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
            r_total    <= '0;
            r_clr_cnt  <= '0;
        end else begin
            r_wb_valid <= w_stat.valid;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (r_wb_valid && r_wb_hit && !r_is_read) begin
                if (r_on && !w_old.shown) begin
                    r_total <= r_total + CNT_W'(1);
                end else if (!r_on && w_old.shown) begin
                    r_total <= r_total - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_hit  <= w_stat.hit;
        r_wb_addr <= w_stat.addr;
        if (w_accept) begin
            r_rd <= '0;
        end else if (r_wb_valid && r_is_read) begin
            r_rd <= w_old;
        end
    end

    assign o_res.status      = r_status;
    assign o_res.read_shown  = r_rd.shown;
    assign o_res.read_red    = r_rd.red;
    assign o_res.read_green  = r_rd.green;
    assign o_res.read_blue   = r_rd.blue;
    assign o_res.read_alpha  = r_rd.alpha;
    assign o_res.shown_count = r_total;
endmodule

`default_nettype wire

// File: hw/rtl/vsf_checker.sv
// Port-level checks of the voxel shape fill engine, bound to the top level.
// Depends on vsf_pkg and voxel_shape_fill_engine_core.
`default_nettype none

module vsf_checker import vsf_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_valid,
    input logic             i_cmd_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [CNT_W-1:0] i_res_count
);
    // one item in flight: taking an item drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("ready stayed high after an item was taken");

    // no new item while a result waits
    a_no_take_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_cmd_ready)
        else $error("ready high while a result is pending");

    // taking a result drops valid
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready) |=> !i_res_valid)
        else $error("second result without a new item");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_count)))
        else $error("stalled result changed");
endmodule

bind voxel_shape_fill_engine_core vsf_checker u_vsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_count (o_res.shown_count)
);

`default_nettype wire

// File: tb/tb_voxel_shape_fill_engine_core.sv
// Self-checking testbench for voxel_shape_fill_engine_core: drives commands and
// config writes, predicts each result with a behavioral voxel store and checks it.
// Depends on vsf_pkg, vsf_cmd_if, vsf_res_if and the engine RTL.
`timescale 1ns / 1ps

module tb_voxel_shape_fill_engine_core;
    import vsf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 3'd7;
    localparam logic [OP_W-1:0]      OP_FIRST_UNUSED = 4'd9;
    localparam logic [OP_W-1:0]      OP_LAST_UNUSED  = 4'd15;
    localparam int IDLE_LIMIT   = 200000;  // covers the clearing sweep plus a full-grid scan
    localparam int SETTLE_TICKS = 40;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [POS_W-1:0] px, py, pz, ex, ey, ez;
        logic [RAD_W-1:0]        rx, ry, rz;
    } cmd_t;

    typedef struct {
        logic               status;
        logic               shown;
        logic [COLOR_W-1:0] red, green, blue, alpha;
        logic [CNT_W-1:0]   count;
    } res_t;

    // Voxel store model: predicts each result and checks it in arrival order.
    class voxel_scoreboard;
        bit                 shown[CELLS];
        logic [COLOR_W-1:0] color[CELLS][4];
        int                 total;
        logic [COLOR_W-1:0] paint[4];
        logic [SIZE_W-1:0]  size[3];
        res_t               pending[$];
        int                 errors;

        function new();
            foreach (shown[i]) begin
                shown[i] = 1'b0;
                for (int c = 0; c < 4; c++) color[i][c] = '0;
            end
            total = 0;
            for (int c = 0; c < 4; c++) paint[c] = '0;
            for (int a = 0; a < 3; a++) size[a] = SIZE_W'(32);
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx <= CFG_ALPHA) paint[idx] = data;
            else if (idx <= CFG_SIZE_Z) size[idx - CFG_SIZE_X] = data[SIZE_W-1:0];
        endfunction

        function int span(int a, int grid);
            return (size[a] < grid) ? int'(size[a]) : grid;
        endfunction

        function void paint_cell(int x, int y, int z, bit on);
            int idx;
            idx = (x * GRID_Y + y) * GRID_Z + z;
            if (on) begin
                if (!shown[idx]) total++;
                shown[idx] = 1'b1;
                for (int c = 0; c < 4; c++) color[idx][c] = paint[c];
            end else begin
                if (shown[idx]) total--;
                shown[idx] = 1'b0;
            end
        endfunction

        // Work out the result of one accepted command and apply it to the store.
        function void note_command(cmd_t c);
            res_t   r;
            int     nx, ny, nz, idx;
            bit     on;
            longint dx, dy, dz, a2, b2, c2, lim, s;
            nx = span(0, GRID_X);
            ny = span(1, GRID_Y);
            nz = span(2, GRID_Z);
            on = !c.op[0];
            r = '{default: '0};
            case (c.op)
                OP_SET_VOX, OP_CLR_VOX, OP_READ: begin
                    if (c.px < 0 || c.px >= nx || c.py < 0 || c.py >= ny ||
                        c.pz < 0 || c.pz >= nz) begin
                        r.status = 1'b1;
                    end else if (c.op == OP_READ) begin
                        idx = (int'(c.px) * GRID_Y + int'(c.py)) * GRID_Z + int'(c.pz);
                        r.shown = shown[idx];
                        r.red   = color[idx][0];
                        r.green = color[idx][1];
                        r.blue  = color[idx][2];
                        r.alpha = color[idx][3];
                    end else begin
                        paint_cell(int'(c.px), int'(c.py), int'(c.pz), on);
                    end
                end
                OP_SET_BOX, OP_CLR_BOX: begin
                    for (int i = (c.px < 0 ? 0 : c.px); i < (c.ex > nx ? nx : c.ex); i++)
                        for (int j = (c.py < 0 ? 0 : c.py); j < (c.ey > ny ? ny : c.ey); j++)
                            for (int k = (c.pz < 0 ? 0 : c.pz); k < (c.ez > nz ? nz : c.ez); k++)
                                paint_cell(i, j, k, on);
                end
                OP_SET_SPH, OP_CLR_SPH: begin
                    a2 = longint'(c.rx) * c.rx;
                    for (int i = 0; i < nx; i++)
                        for (int j = 0; j < ny; j++)
                            for (int k = 0; k < nz; k++) begin
                                dx = i - c.px; dy = j - c.py; dz = k - c.pz;
                                if (dx * dx + dy * dy + dz * dz <= a2) paint_cell(i, j, k, on);
                            end
                end
                OP_SET_ELL, OP_CLR_ELL: begin
                    // any zero semi-axis leaves the store alone
                    if (c.rx != 0 && c.ry != 0 && c.rz != 0) begin
                        a2 = longint'(c.rx) * c.rx;
                        b2 = longint'(c.ry) * c.ry;
                        c2 = longint'(c.rz) * c.rz;
                        lim = a2 * b2 * c2;
                        for (int i = 0; i < nx; i++)
                            for (int j = 0; j < ny; j++)
                                for (int k = 0; k < nz; k++) begin
                                    dx = i - c.px; dy = j - c.py; dz = k - c.pz;
                                    s = dx * dx * b2 * c2 + dy * dy * a2 * c2 + dz * dz * a2 * b2;
                                    if (s <= lim) paint_cell(i, j, k, on);
                                end
                    end
                end
                default: ;
            endcase
            r.count = total[CNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endfunction

        function void check_result(res_t got);
            res_t e;
            if (pending.size() == 0) begin
                report("result with no command pending, count", got.count, 0);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) report("status", got.status, e.status);
            if (got.shown !== e.shown)   report("read_shown", got.shown, e.shown);
            if (got.red !== e.red)       report("read_red", got.red, e.red);
            if (got.green !== e.green)   report("read_green", got.green, e.green);
            if (got.blue !== e.blue)     report("read_blue", got.blue, e.blue);
            if (got.alpha !== e.alpha)   report("read_alpha", got.alpha, e.alpha);
            if (got.count !== e.count)   report("shown_count", got.count, e.count);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vsf_cmd_if cmd_bus ();
    vsf_res_if res_bus ();

    voxel_shape_fill_engine_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_bus.sink),
        .o_res      (res_bus.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    voxel_scoreboard board;
    bit  steady;        // when set, neither side idles
    int  idle_ticks;
    int  stall_left;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: stall the engine at random.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_bus.ready <= 1'b0;
        end else if (!res_bus.ready) begin
            res_bus.ready <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            res_bus.ready <= (pick_gap() == 0);
        end
    end

    // Watch both handshakes; note commands, check results, count quiet cycles.
    always @(posedge i_clk) begin
        res_t got;
        cmd_t c;
        if (cmd_bus.valid && cmd_bus.ready) begin
            c.op = cmd_bus.opcode;
            c.px = cmd_bus.pos_x; c.py = cmd_bus.pos_y; c.pz = cmd_bus.pos_z;
            c.ex = cmd_bus.end_x; c.ey = cmd_bus.end_y; c.ez = cmd_bus.end_z;
            c.rx = cmd_bus.radius_x; c.ry = cmd_bus.radius_y; c.rz = cmd_bus.radius_z;
            board.note_command(c);
        end
        if (res_bus.valid && res_bus.ready) begin
            got.status = res_bus.status;
            got.shown  = res_bus.read_shown;
            got.red    = res_bus.read_red;
            got.green  = res_bus.read_green;
            got.blue   = res_bus.read_blue;
            got.alpha  = res_bus.read_alpha;
            got.count  = res_bus.shown_count;
            board.check_result(got);
        end
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_ticks <= 0;
        end else if (idle_ticks >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_ticks <= idle_ticks + 1;
        end
    end

    // Hold one command on the bus until it is taken.
    task automatic send(cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.opcode   <= c.op;
        cmd_bus.pos_x    <= c.px; cmd_bus.pos_y <= c.py; cmd_bus.pos_z <= c.pz;
        cmd_bus.end_x    <= c.ex; cmd_bus.end_y <= c.ey; cmd_bus.end_z <= c.ez;
        cmd_bus.radius_x <= c.rx; cmd_bus.radius_y <= c.ry; cmd_bus.radius_z <= c.rz;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    task automatic build_send(logic [OP_W-1:0] op, int px, int py, int pz,
                              int ex, int ey, int ez, int rx, int ry, int rz);
        cmd_t c;
        c.op = op;
        c.px = POS_W'(px); c.py = POS_W'(py); c.pz = POS_W'(pz);
        c.ex = POS_W'(ex); c.ey = POS_W'(ey); c.ez = POS_W'(ez);
        c.rx = RAD_W'(rx); c.ry = RAD_W'(ry); c.rz = RAD_W'(rz);
        send(c);
    endtask

    // Drop valid, then let every pending result come back before touching config.
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_phase(int r, int g, int b, int a, int sx, int sy, int sz);
        cfg_write(CFG_RED, CFG_DATA_W'(r));
        cfg_write(CFG_GREEN, CFG_DATA_W'(g));
        cfg_write(CFG_BLUE, CFG_DATA_W'(b));
        cfg_write(CFG_ALPHA, CFG_DATA_W'(a));
        cfg_write(CFG_SIZE_X, CFG_DATA_W'(sx));
        cfg_write(CFG_SIZE_Y, CFG_DATA_W'(sy));
        cfg_write(CFG_SIZE_Z, CFG_DATA_W'(sz));
    endtask

    // A coordinate near the active grid, occasionally anywhere in range.
    function automatic int near(int ext);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255) - 128;
        return $urandom_range(0, ext + 3) - 2;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   roll, ext[3];
        for (int a = 0; a < 3; a++) ext[a] = board.span(a, 32);
        roll = $urandom_range(0, 99);
        if (roll < 30) c.op = OP_W'($urandom_range(OP_SET_VOX, OP_CLR_VOX));
        else if (roll < 50) c.op = OP_READ;
        else if (roll < 70) c.op = OP_W'($urandom_range(OP_SET_BOX, OP_CLR_BOX));
        else if (roll < 95) c.op = OP_W'($urandom_range(OP_SET_SPH, OP_CLR_ELL));
        else c.op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        c.px = POS_W'(near(ext[0])); c.py = POS_W'(near(ext[1])); c.pz = POS_W'(near(ext[2]));
        c.ex = POS_W'(near(ext[0]) + 1); c.ey = POS_W'(near(ext[1]) + 1);
        c.ez = POS_W'(near(ext[2]) + 1);
        if ($urandom_range(0, 7) == 0) begin
            c.rx = RAD_W'($urandom_range(0, 127)); c.ry = RAD_W'($urandom_range(0, 127));
            c.rz = RAD_W'($urandom_range(0, 127));
        end else begin
            c.rx = RAD_W'($urandom_range(0, 6)); c.ry = RAD_W'($urandom_range(0, 6));
            c.rz = RAD_W'($urandom_range(0, 6));
        end
        return c;
    endfunction

    initial begin
        board = new();
        steady = 0;
        idle_ticks = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.opcode = '0;
        cmd_bus.pos_x = '0; cmd_bus.pos_y = '0; cmd_bus.pos_z = '0;
        cmd_bus.end_x = '0; cmd_bus.end_y = '0; cmd_bus.end_z = '0;
        cmd_bus.radius_x = '0; cmd_bus.radius_y = '0; cmd_bus.radius_z = '0;
        res_bus.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: full grid, black paint. A full-grid sphere scan hitting no voxel.
        build_send(OP_READ, 31, 31, 31, 0, 0, 0, 0, 0, 0);
        build_send(OP_SET_VOX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        build_send(OP_SET_SPH, -128, -128, -128, 0, 0, 0, 127, 0, 0);
        build_send(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Small grid; walk every operation and the corner cases.
        set_phase(255, 0, 128, 1, 4, 5, 3);
        cfg_write(CFG_UNUSED, 8'hff);          // ignored index
        steady = 1;
        build_send(OP_SET_VOX, 3, 4, 2, 0, 0, 0, 0, 0, 0);
        build_send(OP_READ, 3, 4, 2, 0, 0, 0, 0, 0, 0);
        build_send(OP_SET_VOX, 4, 0, 0, 0, 0, 0, 0, 0, 0);     // just outside x
        build_send(OP_READ, 127, -128, 0, 0, 0, 0, 0, 0, 0);  // outside, fields zero
        build_send(OP_CLR_VOX, 3, 4, 2, 0, 0, 0, 0, 0, 0);
        build_send(OP_READ, 3, 4, 2, 0, 0, 0, 0, 0, 0);       // color kept, hidden
        steady = 0;
        build_send(OP_SET_BOX, -128, -128, -128, 127, 127, 127, 0, 0, 0);
        build_send(OP_CLR_BOX, 1, 1, 1, 3, 3, 2, 0, 0, 0);
        build_send(OP_SET_BOX, 3, 2, 1, 1, 4, 2, 0, 0, 0);     // inverted, no effect
        build_send(OP_CLR_SPH, 2, 2, 1, 0, 0, 0, 1, 0, 0);
        build_send(OP_SET_SPH, 0, 0, 0, 0, 0, 0, 0, 0, 0);     // radius zero: center only
        build_send(OP_CLR_ELL, 2, 2, 1, 0, 0, 0, 2, 3, 1);
        build_send(OP_SET_ELL, 1, 1, 1, 0, 0, 0, 0, 5, 5);     // zero semi-axis
        build_send(OP_SET_ELL, 1, 2, 1, 0, 0, 0, 127, 1, 127);
        build_send(OP_FIRST_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        build_send(OP_LAST_UNUSED, 1, 1, 1, 0, 0, 0, 0, 0, 0);
        build_send(OP_READ, 2, 2, 1, 0, 0, 0, 0, 0, 0);
        drain();

        // Oversized and empty extents; the shrunk grid leaves old voxels counted.
        set_phase(0, 255, 17, 254, 63, 1, 1);
        build_send(OP_SET_BOX, 20, 0, 0, 40, 5, 5, 0, 0, 0);
        build_send(OP_READ, 31, 0, 0, 0, 0, 0, 0, 0, 0);
        build_send(OP_READ, 3, 4, 2, 0, 0, 0, 0, 0, 0);        // now outside y
        build_send(OP_SET_SPH, 10, 0, 0, 0, 0, 0, 3, 0, 0);
        drain();
        set_phase(9, 9, 9, 9, 0, 7, 7);
        build_send(OP_SET_SPH, 0, 0, 0, 0, 0, 0, 5, 0, 0);
        build_send(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Random phases on small grids.
        for (int p = 0; p < 5; p++) begin
            set_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(1, 8), $urandom_range(1, 8),
                      $urandom_range(1, 8));
            steady = (p == 2);
            for (int n = 0; n < 15; n++) send(random_cmd());
            drain();
        end

        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: voxel_shape_fill_engine_core.f
hw/rtl/vsf_pkg.sv
hw/rtl/vsf_cmd_if.sv
hw/rtl/vsf_res_if.sv
hw/rtl/vsf_ram.sv
hw/rtl/vsf_hit.sv
hw/rtl/voxel_shape_fill_engine_core.sv
hw/rtl/vsf_checker.sv
tb/tb_voxel_shape_fill_engine_core.sv
